// File: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: sv/pbc_pkg.sv
`default_nettype none

package pbc_pkg;

    localparam int VAR_W      = 14;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [7:0]       STEP_EDGE  = 8'd16;
    localparam logic [7:0]       EDGE_LIMIT = 8'd24;
    localparam logic [8:0]       VAR_BASE   = 9'd96;
    localparam logic [VAR_W-1:0] VAR_MAX    = 14'd16383;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUANTIZER    = 2'd0,
        CFG_FASTEST      = 2'd1,
        CFG_FRAME_WIDTH  = 2'd2,
        CFG_FRAME_HEIGHT = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        HINT_NONE = 2'd0,
        HINT_HORZ = 2'd1,
        HINT_VERT = 2'd2
    } hint_t;

    typedef enum logic [1:0] {
        DEC_UNSPLIT = 2'd0,
        DEC_SPLIT   = 2'd1,
        DEC_TRIAL   = 2'd2
    } decision_t;

    typedef struct packed {
        logic [7:0]  quantizer;
        logic        fastest_speed;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
    } cfg_t;

endpackage

`default_nettype wire

// File: sv/pbc_if.sv
`default_nettype none

// Sample channel.
interface pbc_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  sample;
    logic        block_start;
    logic [1:0]  block_size_code;
    logic [13:0] block_row;
    logic [13:0] block_column;

    modport source (output valid, sample, block_start, block_size_code, block_row,
                    block_column, input ready);
    modport sink (input valid, sample, block_start, block_size_code, block_row,
                  block_column, output ready);
endinterface

// Result channel.
interface pbc_out_if;
    logic        valid;
    logic        ready;
    logic        no_split_ok;
    logic [1:0]  rectangle_hint;
    logic [1:0]  decision;
    logic [13:0] block_variance;
    logic [7:0]  largest_edge;

    modport source (output valid, no_split_ok, rectangle_hint, decision, block_variance,
                    largest_edge, input ready);
    modport sink (input valid, no_split_ok, rectangle_hint, decision, block_variance,
                  largest_edge, output ready);
endinterface

`default_nettype wire

// File: sv/pbc_accum.sv
`default_nettype none

module pbc_accum
    import pbc_pkg::*;
#(
    parameter int MAX_SIDE_PIXELS = 32,
    parameter int PALETTE_LIMIT   = 8
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic take,
    input  wire logic [7:0] sample,
    input  wire logic start,
    input  wire logic [$clog2($clog2(MAX_SIDE_PIXELS+1)):0] start_log,
    input  wire logic start_fit,
    output logic done,
    output logic [8+2*($clog2(MAX_SIDE_PIXELS+1)-1)-1:0] fin_sum,
    output logic [16+2*($clog2(MAX_SIDE_PIXELS+1)-1)-1:0] fin_sq,
    output logic [$clog2(PALETTE_LIMIT+2)-1:0] fin_pal,
    output logic [7:0] fin_peak,
    output logic [8+2*($clog2(MAX_SIDE_PIXELS+1)-1)-1:0] fin_row_act,
    output logic [8+2*($clog2(MAX_SIDE_PIXELS+1)-1)-1:0] fin_col_act,
    output logic [2*($clog2(MAX_SIDE_PIXELS+1)-1)-1:0] fin_row_edges,
    output logic [2*($clog2(MAX_SIDE_PIXELS+1)-1)-1:0] fin_col_edges,
    output logic [$clog2($clog2(MAX_SIDE_PIXELS+1)):0] fin_log,
    output logic fin_fit
);

    localparam int SIDE_LOG_MAX = $clog2(MAX_SIDE_PIXELS + 1) - 1;
    localparam int LOG_W        = $clog2(SIDE_LOG_MAX + 1) + 1;
    localparam int POS_W        = SIDE_LOG_MAX;
    localparam int LINE_DEPTH   = 1 << SIDE_LOG_MAX;
    localparam int SUM_W        = 8 + 2 * SIDE_LOG_MAX;
    localparam int SQ_W         = 16 + 2 * SIDE_LOG_MAX;
    localparam int CNT_W        = 2 * SIDE_LOG_MAX;
    localparam int PAL_CNT_W    = $clog2(PALETTE_LIMIT + 2);
    localparam int PAL_IDX_W    = $clog2(PALETTE_LIMIT);
    localparam logic [LOG_W-1:0]     LOG_RESET = LOG_W'(3);
    localparam logic [PAL_CNT_W-1:0] PAL_FULL  = PAL_CNT_W'(PALETTE_LIMIT);

    logic [LOG_W-1:0]     log_reg;
    logic                 fit_reg;
    logic [POS_W-1:0]     x_reg, y_reg;
    logic [7:0]           left_reg;
    logic [SUM_W-1:0]     sum_reg, row_act_reg, col_act_reg;
    logic [SQ_W-1:0]      sq_reg;
    logic [PAL_CNT_W-1:0] pal_cnt_reg;
    logic [7:0]           peak_reg;
    logic [CNT_W-1:0]     row_edg_reg, col_edg_reg;
    logic [7:0]           pal_val_reg [PALETTE_LIMIT];
    logic [7:0]           line_mem_reg [LINE_DEPTH];
    logic [7:0]           up_rd_reg;

    logic [LOG_W-1:0]     cur_log;
    logic                 cur_fit;
    logic [POS_W-1:0]     base_x, base_y, side_mask, x_next, y_next, rd_addr;
    logic [SUM_W-1:0]     base_sum, base_row_act, base_col_act;
    logic [SQ_W-1:0]      base_sq;
    logic [PAL_CNT_W-1:0] base_cnt, cnt_next;
    logic [7:0]           base_peak, base_left, peak_next;
    logic [CNT_W-1:0]     base_row_edg, base_col_edg;
    logic                 last_x, last_y, left_ok, up_ok, match, pal_we;
    logic [15:0]          s_sq;
    logic [7:0]           e_left, e_up;
    logic [SUM_W-1:0]     sum_next, row_act_next, col_act_next;
    logic [SQ_W-1:0]      sq_next;
    logic [CNT_W-1:0]     row_edg_next, col_edg_next;
    logic [PAL_IDX_W-1:0] pal_idx;

    // A start sample sees a cleared block.
    assign cur_log      = start ? start_log : log_reg;
    assign cur_fit      = start ? start_fit : fit_reg;
    assign base_x       = start ? '0 : x_reg;
    assign base_y       = start ? '0 : y_reg;
    assign base_sum     = start ? '0 : sum_reg;
    assign base_sq      = start ? '0 : sq_reg;
    assign base_cnt     = start ? '0 : pal_cnt_reg;
    assign base_peak    = start ? '0 : peak_reg;
    assign base_left    = start ? '0 : left_reg;
    assign base_row_act = start ? '0 : row_act_reg;
    assign base_col_act = start ? '0 : col_act_reg;
    assign base_row_edg = start ? '0 : row_edg_reg;
    assign base_col_edg = start ? '0 : col_edg_reg;

    assign side_mask = ~({POS_W{1'b1}} << cur_log);
    assign last_x    = (base_x == side_mask);
    assign last_y    = (base_y == side_mask);
    assign done      = take && last_x && last_y;
    assign x_next    = last_x ? '0 : base_x + POS_W'(1);
    assign y_next    = last_x ? (last_y ? '0 : base_y + POS_W'(1)) : base_y;

    // Line buffer read runs one pixel ahead of the consumer.
    assign rd_addr = take ? x_next : x_reg;

    assign left_ok = (base_x != '0);
    assign up_ok   = (base_y != '0);
    assign e_left  = (sample > base_left) ? sample - base_left : base_left - sample;
    assign e_up    = (sample > up_rd_reg) ? sample - up_rd_reg : up_rd_reg - sample;
    assign s_sq    = {8'd0, sample} * {8'd0, sample};

    always_comb
    begin
        peak_next = base_peak;
        if (left_ok && e_left > peak_next)
        begin
            peak_next = e_left;
        end
        if (up_ok && e_up > peak_next)
        begin
            peak_next = e_up;
        end
    end

    assign sum_next     = base_sum + SUM_W'(sample);
    assign sq_next      = base_sq + SQ_W'(s_sq);
    assign row_act_next = base_row_act + (left_ok ? SUM_W'(e_left) : '0);
    assign col_act_next = base_col_act + (up_ok ? SUM_W'(e_up) : '0);
    assign row_edg_next = base_row_edg + CNT_W'(left_ok && (e_left > STEP_EDGE));
    assign col_edg_next = base_col_edg + CNT_W'(up_ok && (e_up > STEP_EDGE));

    // Palette: parallel compare against the filled entries.
    always_comb
    begin
        match = 1'b0;
        for (int i = 0; i < PALETTE_LIMIT; i++)
        begin
            if ((PAL_CNT_W'(i) < base_cnt) && (pal_val_reg[i] == sample))
            begin
                match = 1'b1;
            end
        end
        cnt_next = base_cnt;
        if ((base_cnt <= PAL_FULL) && !match)
        begin
            cnt_next = (base_cnt < PAL_FULL) ? base_cnt + PAL_CNT_W'(1)
                                             : PAL_FULL + PAL_CNT_W'(1);
        end
    end

    assign pal_we  = take && (base_cnt < PAL_FULL) && !match;
    assign pal_idx = PAL_IDX_W'(base_cnt);

    assign fin_sum       = sum_next;
    assign fin_sq        = sq_next;
    assign fin_pal       = cnt_next;
    assign fin_peak      = peak_next;
    assign fin_row_act   = row_act_next;
    assign fin_col_act   = col_act_next;
    assign fin_row_edges = row_edg_next;
    assign fin_col_edges = col_edg_next;
    assign fin_log       = cur_log;
    assign fin_fit       = cur_fit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_reg     <= LOG_RESET;
            fit_reg     <= 1'b0;
            x_reg       <= '0;
            y_reg       <= '0;
            left_reg    <= '0;
            sum_reg     <= '0;
            sq_reg      <= '0;
            pal_cnt_reg <= '0;
            peak_reg    <= '0;
            row_act_reg <= '0;
            col_act_reg <= '0;
            row_edg_reg <= '0;
            col_edg_reg <= '0;
        end
        else if (take)
        begin
            log_reg <= cur_log;
            fit_reg <= cur_fit;
            x_reg   <= x_next;
            y_reg   <= y_next;
            if (done)
            begin
                left_reg    <= '0;
                sum_reg     <= '0;
                sq_reg      <= '0;
                pal_cnt_reg <= '0;
                peak_reg    <= '0;
                row_act_reg <= '0;
                col_act_reg <= '0;
                row_edg_reg <= '0;
                col_edg_reg <= '0;
            end
            else
            begin
                left_reg    <= sample;
                sum_reg     <= sum_next;
                sq_reg      <= sq_next;
                pal_cnt_reg <= cnt_next;
                peak_reg    <= peak_next;
                row_act_reg <= row_act_next;
                col_act_reg <= col_act_next;
                row_edg_reg <= row_edg_next;
                col_edg_reg <= col_edg_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_val_reg[pal_idx] <= sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            line_mem_reg[base_x] <= sample;
        end
        up_rd_reg <= line_mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

// File: sv/pbc_finalize.sv
`default_nettype none

module pbc_finalize
    import pbc_pkg::*;
#(
    parameter int MAX_SIDE_PIXELS = 32,
    parameter int PALETTE_LIMIT   = 8
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic snap_load,
    input  wire logic [8+2*($clog2(MAX_SIDE_PIXELS+1)-1)-1:0] fin_sum,
    input  wire logic [16+2*($clog2(MAX_SIDE_PIXELS+1)-1)-1:0] fin_sq,
    input  wire logic [$clog2(PALETTE_LIMIT+2)-1:0] fin_pal,
    input  wire logic [7:0] fin_peak,
    input  wire logic [8+2*($clog2(MAX_SIDE_PIXELS+1)-1)-1:0] fin_row_act,
    input  wire logic [8+2*($clog2(MAX_SIDE_PIXELS+1)-1)-1:0] fin_col_act,
    input  wire logic [2*($clog2(MAX_SIDE_PIXELS+1)-1)-1:0] fin_row_edges,
    input  wire logic [2*($clog2(MAX_SIDE_PIXELS+1)-1)-1:0] fin_col_edges,
    input  wire logic [$clog2($clog2(MAX_SIDE_PIXELS+1)):0] fin_log,
    input  wire logic fin_fit,
    output logic snap_free,
    output logic out_valid,
    input  wire logic out_ready,
    output logic no_split_ok,
    output logic [1:0] rectangle_hint,
    output logic [1:0] decision,
    output logic [VAR_W-1:0] block_variance,
    output logic [7:0] largest_edge
);

    localparam int SIDE_LOG_MAX = $clog2(MAX_SIDE_PIXELS + 1) - 1;
    localparam int LOG_W        = $clog2(SIDE_LOG_MAX + 1) + 1;
    localparam int SUM_W        = 8 + 2 * SIDE_LOG_MAX;
    localparam int SQ_W         = 16 + 2 * SIDE_LOG_MAX;
    localparam int CNT_W        = 2 * SIDE_LOG_MAX;
    localparam int PAL_CNT_W    = $clog2(PALETTE_LIMIT + 2);
    localparam int DW           = 2 * SUM_W;
    localparam int ACT_W        = SUM_W + 2;
    localparam logic [PAL_CNT_W-1:0] PAL_FULL = PAL_CNT_W'(PALETTE_LIMIT);

    // Stage 1: snapshot of the finished block.
    logic                 s1_v_reg;
    logic [SUM_W-1:0]     s1_sum_reg, s1_row_act_reg, s1_col_act_reg;
    logic [SQ_W-1:0]      s1_sq_reg;
    logic [PAL_CNT_W-1:0] s1_pal_reg;
    logic [7:0]           s1_peak_reg;
    logic [CNT_W-1:0]     s1_row_edg_reg, s1_col_edg_reg;
    logic [LOG_W-1:0]     s1_log_reg;
    logic                 s1_fit_reg;

    // Stage 2: squared sum, hint.
    logic                 s2_v_reg;
    logic [DW-1:0]        s2_prod_reg;
    logic [SQ_W-1:0]      s2_sq_reg;
    logic [LOG_W-1:0]     s2_log_reg;
    logic [7:0]           s2_peak_reg;
    logic                 s2_fit_reg, s2_pal_ok_reg;
    hint_t                s2_hint_reg;

    // Stage 3: variance.
    logic                 s3_v_reg;
    logic [VAR_W-1:0]     s3_var_reg;
    logic [7:0]           s3_peak_reg;
    logic                 s3_fit_reg, s3_pal_ok_reg;
    hint_t                s3_hint_reg;

    // Output register.
    logic                 out_v_reg;
    logic                 out_none_reg;
    hint_t                out_hint_reg;
    decision_t            out_dec_reg;
    logic [VAR_W-1:0]     out_var_reg;
    logic [7:0]           out_peak_reg;

    logic out_free, s3_free, s2_free, s1_free;

    assign out_free  = !out_v_reg || out_ready;
    assign s3_free   = !s3_v_reg || out_free;
    assign s2_free   = !s2_v_reg || s3_free;
    assign s1_free   = !s1_v_reg || s2_free;
    assign snap_free = s1_free;

    // Stage 2 logic
    logic [DW-1:0]    prod;
    logic [CNT_W:0]   lo, hi;
    logic [ACT_W-1:0] pp, row_lim, col_lim;
    logic             hint_on, horz, vert, pal_ok;
    hint_t            hint;

    assign prod    = DW'(s1_sum_reg) * DW'(s1_sum_reg);
    assign lo      = (CNT_W + 1)'(3) << (s1_log_reg - LOG_W'(2));
    assign hi      = (CNT_W + 1)'(5) << (s1_log_reg - LOG_W'(2));
    assign pp      = ACT_W'(1) << {s1_log_reg, 1'b0};
    assign row_lim = {1'b0, s1_row_act_reg, 1'b0} + pp;
    assign col_lim = {1'b0, s1_col_act_reg, 1'b0} + pp;
    assign hint_on = s1_fit_reg && !cfg.fastest_speed
                     && ((s1_log_reg == LOG_W'(4)) || (s1_log_reg == LOG_W'(5)));
    assign horz    = ({1'b0, s1_col_edg_reg} >= lo) && ({1'b0, s1_col_edg_reg} <= hi)
                     && (ACT_W'(s1_col_act_reg) > row_lim);
    assign vert    = ({1'b0, s1_row_edg_reg} >= lo) && ({1'b0, s1_row_edg_reg} <= hi)
                     && (ACT_W'(s1_row_act_reg) > col_lim);
    assign pal_ok  = (s1_pal_reg >= PAL_CNT_W'(2)) && (s1_pal_reg <= PAL_FULL);

    always_comb
    begin
        hint = HINT_NONE;
        if (hint_on && horz)
        begin
            hint = HINT_HORZ;
        end
        else if (hint_on && vert)
        begin
            hint = HINT_VERT;
        end
    end

    // Stage 3 logic: (sq*n - sum^2) / n^2 with n a power of two.
    logic [DW-1:0]    diff, var_full;
    logic [VAR_W-1:0] var_sat;

    assign diff     = (DW'(s2_sq_reg) << {s2_log_reg, 1'b0}) - s2_prod_reg;
    assign var_full = diff >> {s2_log_reg, 2'b00};
    assign var_sat  = (var_full > DW'(VAR_MAX)) ? VAR_MAX : var_full[VAR_W-1:0];

    // Output logic
    logic [8:0] var_lim;
    logic       none;
    decision_t  dec;

    assign var_lim = VAR_BASE + 9'(cfg.quantizer[7:2]);
    assign none    = s3_fit_reg && (s3_pal_ok_reg
                     || ((s3_var_reg <= VAR_W'(var_lim)) && (s3_peak_reg <= EDGE_LIMIT)));

    always_comb
    begin
        if (cfg.fastest_speed)
        begin
            dec = none ? DEC_UNSPLIT : DEC_SPLIT;
        end
        else if (!none && (s3_hint_reg == HINT_NONE))
        begin
            dec = DEC_SPLIT;
        end
        else
        begin
            dec = DEC_TRIAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_v_reg <= snap_load;
            end
            if (s2_free)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (s3_free)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (out_free)
            begin
                out_v_reg <= s3_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && snap_load)
        begin
            s1_sum_reg     <= fin_sum;
            s1_sq_reg      <= fin_sq;
            s1_pal_reg     <= fin_pal;
            s1_peak_reg    <= fin_peak;
            s1_row_act_reg <= fin_row_act;
            s1_col_act_reg <= fin_col_act;
            s1_row_edg_reg <= fin_row_edges;
            s1_col_edg_reg <= fin_col_edges;
            s1_log_reg     <= fin_log;
            s1_fit_reg     <= fin_fit;
        end
        if (s2_free && s1_v_reg)
        begin
            s2_prod_reg   <= prod;
            s2_sq_reg     <= s1_sq_reg;
            s2_log_reg    <= s1_log_reg;
            s2_peak_reg   <= s1_peak_reg;
            s2_fit_reg    <= s1_fit_reg;
            s2_pal_ok_reg <= pal_ok;
            s2_hint_reg   <= hint;
        end
        if (s3_free && s2_v_reg)
        begin
            s3_var_reg    <= var_sat;
            s3_peak_reg   <= s2_peak_reg;
            s3_fit_reg    <= s2_fit_reg;
            s3_pal_ok_reg <= s2_pal_ok_reg;
            s3_hint_reg   <= s2_hint_reg;
        end
        if (out_free && s3_v_reg)
        begin
            out_none_reg <= none;
            out_hint_reg <= s3_hint_reg;
            out_dec_reg  <= dec;
            out_var_reg  <= s3_var_reg;
            out_peak_reg <= s3_peak_reg;
        end
    end

    assign out_valid      = out_v_reg;
    assign no_split_ok    = out_none_reg;
    assign rectangle_hint = out_hint_reg;
    assign decision       = out_dec_reg;
    assign block_variance = out_var_reg;
    assign largest_edge   = out_peak_reg;

endmodule

`default_nettype wire

// File: sv/partition_block_classifier.sv
// A result passes the snapshot, stage 2, stage 3 and output registers after the last sample of a block is accepted.
// Throughput: one sample per cycle while input ready is high; the accumulators and line buffer update per sample.
// Input ready drops only when four finished results are held by a stalled result channel.
// Reset (rst_n, async, low): config, counters, sums and pipeline valids clear; held size
// is 8 pixels and the fit flag is 0. Line buffer and palette entries are not cleared.
`default_nettype none

module partition_block_classifier
    import pbc_pkg::*;
#(
    parameter int MAX_SIDE_PIXELS = 32,
    parameter int PALETTE_LIMIT   = 8
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    pbc_in_if.sink    pixels,
    pbc_out_if.source results,
    input  wire logic cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SIDE_LOG_MAX = $clog2(MAX_SIDE_PIXELS + 1) - 1;
    localparam int LOG_W        = $clog2(SIDE_LOG_MAX + 1) + 1;
    localparam int SUM_W        = 8 + 2 * SIDE_LOG_MAX;
    localparam int SQ_W         = 16 + 2 * SIDE_LOG_MAX;
    localparam int CNT_W        = 2 * SIDE_LOG_MAX;
    localparam int PAL_CNT_W    = $clog2(PALETTE_LIMIT + 2);

    // ------------------------------------------------------------------
    // Configuration registers. Written by the user only while idle; the block does not enforce it.
    // ------------------------------------------------------------------
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_QUANTIZER:    cfg_reg.quantizer     <= cfg_data[7:0];
                CFG_FASTEST:      cfg_reg.fastest_speed <= cfg_data[0];
                CFG_FRAME_WIDTH:  cfg_reg.frame_width   <= cfg_data;
                CFG_FRAME_HEIGHT: cfg_reg.frame_height  <= cfg_data;
                default:          cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Block size and frame fit, evaluated on the start sample.
    // Code three counts as 32; sizes above the line buffer shrink to it.
    // ------------------------------------------------------------------
    logic [1:0]       code_clamped;
    logic [LOG_W-1:0] raw_log, start_log;
    logic [14:0]      units, col_end, row_end;
    logic             start_fit;

    assign code_clamped = (pixels.block_size_code > 2'd2) ? 2'd2 : pixels.block_size_code;
    assign raw_log      = LOG_W'(3) + LOG_W'(code_clamped);
    assign start_log    = (raw_log > LOG_W'(SIDE_LOG_MAX)) ? LOG_W'(SIDE_LOG_MAX) : raw_log;
    // side / 4 in 4-pixel units
    assign units        = 15'(1) << (start_log - LOG_W'(2));
    assign col_end      = {1'b0, pixels.block_column} + units;
    assign row_end      = {1'b0, pixels.block_row} + units;
    assign start_fit    = ({col_end, 2'b00} <= {1'b0, cfg_reg.frame_width})
                          && ({row_end, 2'b00} <= {1'b0, cfg_reg.frame_height});

    // ------------------------------------------------------------------
    // Transaction handshake and datapath.
    // ------------------------------------------------------------------
    logic                 take, done, snap_free;
    logic [SUM_W-1:0]     fin_sum, fin_row_act, fin_col_act;
    logic [SQ_W-1:0]      fin_sq;
    logic [PAL_CNT_W-1:0] fin_pal;
    logic [7:0]           fin_peak;
    logic [CNT_W-1:0]     fin_row_edges, fin_col_edges;
    logic [LOG_W-1:0]     fin_log;
    logic                 fin_fit;

    assign pixels.ready = snap_free;
    assign take         = pixels.valid && snap_free;

    pbc_accum #(
        .MAX_SIDE_PIXELS (MAX_SIDE_PIXELS),
        .PALETTE_LIMIT   (PALETTE_LIMIT)
    ) u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .sample        (pixels.sample),
        .start         (pixels.block_start),
        .start_log     (start_log),
        .start_fit     (start_fit),
        .done          (done),
        .fin_sum       (fin_sum),
        .fin_sq        (fin_sq),
        .fin_pal       (fin_pal),
        .fin_peak      (fin_peak),
        .fin_row_act   (fin_row_act),
        .fin_col_act   (fin_col_act),
        .fin_row_edges (fin_row_edges),
        .fin_col_edges (fin_col_edges),
        .fin_log       (fin_log),
        .fin_fit       (fin_fit)
    );

    // Finish pipeline: snapshot, squared sum and hint, variance, result register.
    pbc_finalize #(
        .MAX_SIDE_PIXELS (MAX_SIDE_PIXELS),
        .PALETTE_LIMIT   (PALETTE_LIMIT)
    ) u_finalize (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .snap_load      (done),
        .fin_sum        (fin_sum),
        .fin_sq         (fin_sq),
        .fin_pal        (fin_pal),
        .fin_peak       (fin_peak),
        .fin_row_act    (fin_row_act),
        .fin_col_act    (fin_col_act),
        .fin_row_edges  (fin_row_edges),
        .fin_col_edges  (fin_col_edges),
        .fin_log        (fin_log),
        .fin_fit        (fin_fit),
        .snap_free      (snap_free),
        .out_valid      (results.valid),
        .out_ready      (results.ready),
        .no_split_ok    (results.no_split_ok),
        .rectangle_hint (results.rectangle_hint),
        .decision       (results.decision),
        .block_variance (results.block_variance),
        .largest_edge   (results.largest_edge)
    );

endmodule

`default_nettype wire

// File: sv/pbc_checker.sv
`default_nettype none

`include "assert_macros.svh"

module pbc_checker
    import pbc_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       no_split_ok,
    input wire logic [1:0] rectangle_hint,
    input wire logic [1:0] decision,
    input wire logic [13:0] block_variance
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(block_variance) && $stable(decision))
    `ASSERT_IMPLIES(a_unsplit_needs_ok, clk, rst_n, out_valid && (decision == DEC_UNSPLIT), no_split_ok)
    `ASSERT_IMPLIES(a_hint_trial, clk, rst_n, out_valid && (rectangle_hint != HINT_NONE), decision == DEC_TRIAL)

endmodule

bind partition_block_classifier pbc_checker u_pbc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .no_split_ok    (results.no_split_ok),
    .rectangle_hint (results.rectangle_hint),
    .decision       (results.decision),
    .block_variance (results.block_variance)
);

`default_nettype wire
